>>> hw/rtl/lcabl_pkg.sv
`default_nettype none

package lcabl_pkg;

  localparam int NODE_W = 10;
  localparam int DEPTH_W = 11;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd2047;
  localparam int CMP_W = 17;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/lca_binary_lifting_unit.sv
// Binary-lifting ancestor table with lowest-common-ancestor queries.
// The input channel (in_valid/in_ready) carries command, node_a and node_b.
// An insert transaction stores node_a with parent node_b and gives no result.
// A query transaction returns one transaction on the output channel
// (out_valid/out_ready) that carries the lowest common ancestor.
// One transaction is worked on at a time; in_ready is high only when idle.
// An insert reads the parent's depth, writes the node's depth and level-0
// ancestor, then makes one read of the ancestor memory per higher level.
// A query reads both depths and lifts the deeper node level by level from the
// top, on each lifting level an ancestor read and then a depth read; if the
// lifted node already meets the other one, the result goes straight out.
// Otherwise a second pass makes a paired ancestor read per level, and a final
// ancestor read fetches the parent of the lifted node.
// After reset the block sweeps both memories to zero, one ancestor entry per
// cycle, over NODES rounded up to a power of two times LEVELS rounded up to a
// power of two entries (16384 at the defaults); in_ready stays low.
// The result sits in an output register, so a stalled receiver holds only a
// following query at its final step; inserts go on meanwhile.
`default_nettype none

module lca_binary_lifting_unit #(
  parameter int NODES = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         command,
  input  wire logic [lcabl_pkg::NODE_W-1:0] node_a,
  input  wire logic [lcabl_pkg::NODE_W-1:0] node_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [lcabl_pkg::NODE_W-1:0] ancestor
);

  localparam int NW = lcabl_pkg::NODE_W;
  localparam int DW = lcabl_pkg::DEPTH_W;
  localparam int CW = lcabl_pkg::CMP_W;
  localparam int IW = $clog2(NODES);
  localparam int LB = $clog2(LEVELS);
  localparam int AAW = IW + LB;
  localparam int ANC_DEPTH = 1 << AAW;
  localparam int DEP_DEPTH = 1 << IW;
  localparam logic [LB-1:0] LVL_TOP = LB'(LEVELS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_DEP,
    ST_INS_DEPW,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_DEP,
    ST_Q_SWAP,
    ST_Q_L1,
    ST_Q_L1A,
    ST_Q_L1D,
    ST_Q_EQ,
    ST_Q_L2,
    ST_Q_L2C,
    ST_Q_FIN,
    ST_Q_FINR,
    ST_Q_OUT
  } state_t;

  state_t state;
  logic [LB-1:0] lvl;
  logic [AAW-1:0] clr_cnt;
  logic [NW-1:0] node_x;
  logic [NW-1:0] node_y;
  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic [NW-1:0] res;

  logic [NW-1:0] anc_mem [ANC_DEPTH];
  logic [DW-1:0] dep_mem [DEP_DEPTH];

  logic [NW-1:0] anc_rd_a;
  logic [NW-1:0] anc_rd_b;
  logic [DW-1:0] dep_rd_a;
  logic [DW-1:0] dep_rd_b;

  logic [AAW-1:0] anc_ra;
  logic [AAW-1:0] anc_rb;
  logic [IW-1:0] dep_ra;
  logic [IW-1:0] dep_rb;
  logic anc_we;
  logic [AAW-1:0] anc_wa;
  logic [NW-1:0] anc_wd;
  logic dep_we;
  logic [IW-1:0] dep_wa;
  logic [DW-1:0] dep_wd;

  logic [DW-1:0] dep_inc;
  logic lift;
  logic ins_ok;

  function automatic logic [IW-1:0] idx(input logic [NW-1:0] n);
    return IW'(n);
  endfunction

  function automatic logic [NW-1:0] sanitize(input logic [NW-1:0] n);
    return (CW'(n) < CW'(NODES)) ? n : '0;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign dep_inc = (dep_rd_a == lcabl_pkg::DEPTH_MAX) ? dep_rd_a : dep_rd_a + DW'(1);
  assign lift = (dx >= dy) && (CW'(dx - dy) >= (CW'(1) << lvl));
  assign ins_ok = (node_a != '0) && (CW'(node_a) < CW'(NODES));

  always_comb begin
    anc_ra = {idx(node_x), lvl};
    anc_rb = {idx(node_y), lvl};
    dep_ra = idx(node_x);
    dep_rb = idx(node_y);
    anc_we = 1'b0;
    anc_wa = {idx(node_y), lvl};
    anc_wd = anc_rd_a;
    dep_we = 1'b0;
    dep_wa = idx(node_y);
    dep_wd = dep_inc;
    case (state)
      ST_CLEAR: begin
        anc_we = 1'b1;
        anc_wa = clr_cnt;
        anc_wd = '0;
        dep_we = (clr_cnt[LB-1:0] == '0);
        dep_wa = clr_cnt[AAW-1:LB];
        dep_wd = '0;
      end
      ST_INS_DEPW: begin
        dep_we = 1'b1;
        anc_we = 1'b1;
        anc_wa = {idx(node_y), LB'(0)};
        anc_wd = node_x;
      end
      ST_INS_RD: begin
        anc_ra = {idx(node_x), lvl - LB'(1)};
      end
      ST_INS_WR: begin
        anc_we = 1'b1;
      end
      ST_Q_L1A: begin
        dep_ra = idx(anc_rd_a);
      end
      ST_Q_FIN: begin
        anc_ra = {idx(node_x), LB'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    anc_rd_a <= anc_mem[anc_ra];
    anc_rd_b <= anc_mem[anc_rb];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    dep_rd_a <= dep_mem[dep_ra];
    dep_rd_b <= dep_mem[dep_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      lvl <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_Q_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AAW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (command == lcabl_pkg::CMD_QUERY) begin
              node_x <= sanitize(node_a);
              node_y <= sanitize(node_b);
              state <= ST_Q_DEP;
            end else if (ins_ok) begin
              node_x <= sanitize(node_b);
              node_y <= node_a;
              state <= ST_INS_DEP;
            end
          end
        end
        ST_INS_DEP: begin
          state <= ST_INS_DEPW;
        end
        ST_INS_DEPW: begin
          lvl <= LB'(1);
          state <= ST_INS_RD;
        end
        ST_INS_RD: begin
          state <= ST_INS_WR;
        end
        ST_INS_WR: begin
          node_x <= anc_rd_a;
          if (lvl == LVL_TOP) begin
            state <= ST_IDLE;
          end else begin
            lvl <= lvl + LB'(1);
            state <= ST_INS_RD;
          end
        end
        ST_Q_DEP: begin
          state <= ST_Q_SWAP;
        end
        ST_Q_SWAP: begin
          if (dep_rd_a < dep_rd_b) begin
            node_x <= node_y;
            node_y <= node_x;
            dx <= dep_rd_b;
            dy <= dep_rd_a;
          end else begin
            dx <= dep_rd_a;
            dy <= dep_rd_b;
          end
          lvl <= LVL_TOP;
          state <= ST_Q_L1;
        end
        ST_Q_L1: begin
          if (lift) begin
            state <= ST_Q_L1A;
          end else if (lvl == '0) begin
            state <= ST_Q_EQ;
          end else begin
            lvl <= lvl - LB'(1);
          end
        end
        ST_Q_L1A: begin
          node_x <= anc_rd_a;
          state <= ST_Q_L1D;
        end
        ST_Q_L1D: begin
          dx <= dep_rd_a;
          if (lvl == '0) begin
            state <= ST_Q_EQ;
          end else begin
            lvl <= lvl - LB'(1);
            state <= ST_Q_L1;
          end
        end
        ST_Q_EQ: begin
          if (node_x == node_y) begin
            res <= node_x;
            state <= ST_Q_OUT;
          end else begin
            lvl <= LVL_TOP;
            state <= ST_Q_L2;
          end
        end
        ST_Q_L2: begin
          state <= ST_Q_L2C;
        end
        ST_Q_L2C: begin
          if (anc_rd_a != anc_rd_b) begin
            node_x <= anc_rd_a;
            node_y <= anc_rd_b;
          end
          if (lvl == '0) begin
            state <= ST_Q_FIN;
          end else begin
            lvl <= lvl - LB'(1);
            state <= ST_Q_L2;
          end
        end
        ST_Q_FIN: begin
          state <= ST_Q_FINR;
        end
        ST_Q_FINR: begin
          res <= anc_rd_a;
          state <= ST_Q_OUT;
        end
        ST_Q_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            ancestor <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_query_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == lcabl_pkg::CMD_QUERY) |=> !in_ready)
    else $error("input accepted while a query was in progress");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_Q_OUT))
    else $error("result raised outside the output step");

  a_anc_write_states: assert property (@(posedge clk) disable iff (rst)
    anc_we |-> (state == ST_CLEAR || state == ST_INS_DEPW || state == ST_INS_WR))
    else $error("ancestor memory written outside clear or insert");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready && !out_valid)
    else $error("channel active during the clearing pass");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |-> (lvl <= LVL_TOP))
    else $error("level counter out of range");

endmodule

`default_nettype wire
